/* hw/rtl/rdl_pkg.sv */
// rdl_pkg: shared types, widths and codes of the row dark-line detector
// depends on nothing; imported by the top level and rdl_div
package rdl_pkg;

  // row geometry
  localparam int ROW_LENGTH = 640;
  localparam int IDX_W      = $clog2(ROW_LENGTH);
  localparam int CNT_W      = $clog2(ROW_LENGTH + 1);

  // pixel storage: only the high five bits of a byte are kept
  localparam int BYTE_W    = 8;
  localparam int PIX_W     = 5;
  localparam int PIX_SHIFT = BYTE_W - PIX_W;
  localparam int PIX_MAX   = ((1 << PIX_W) - 1) << PIX_SHIFT;

  // row sum and mean
  localparam int SUM_W  = $clog2(ROW_LENGTH * PIX_MAX + 1);
  localparam int MEAN_W = BYTE_W;
  localparam int DSTEP_W = $clog2(SUM_W + 1);

  // fixed field widths
  localparam int CENTRE_W   = 10;
  localparam int TOTAL_W    = 8;
  localparam int DIST_W     = 4;
  localparam int MINW_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int DIFF_W     = (IDX_W > MINW_W) ? IDX_W : MINW_W;

  // register reset values
  localparam logic [DIST_W-1:0] DIST_RST = DIST_W'(5);
  localparam logic [MINW_W-1:0] MINW_RST = MINW_W'(30);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ONLY = 2'd0,
    CFG_EDGE_DIST  = 2'd1,
    CFG_MIN_WIDTH  = 2'd2
  } cfg_idx_t;

  // input commands
  typedef enum logic [1:0] {
    CMD_PIXEL  = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // input beat
  typedef struct packed {
    cmd_t              command;
    logic [BYTE_W-1:0] pixel_byte;
    logic              last_pixel;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic                row_has_line;
    logic [CENTRE_W-1:0] line_centre;
    logic [TOTAL_W-1:0]  line_total;
    logic                search_on;
  } out_beat_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/row_dark_line_detector.sv */
// row_dark_line_detector: top level, row fill, mean and dark-line scan sequencer
// depends on rdl_pkg, rdl_ram and rdl_div
//
//   port group  dir  handshake          payload
//   in_         in   in_valid/in_stall  in_beat_t (command, pixel_byte, last_pixel)
//   out_        out  out_valid/out_stall out_beat_t (found, centre, total, search_on)
//   cfg_        in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// a pixel or a command is taken in the idle state; a last pixel then waits on the
// divider for the mean, runs each edge test of the scan as a read state and an
// evaluate state when search is armed, and loads the result register in S_DONE.
// the row ram needs no clearing pass: only pixels of the current row are compared.
// in_stall stays high from a last pixel until its result sits in the output
// register; out_stall only holds that register and a finished row behind it.
module row_dark_line_detector
  import rdl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic                first_r;
  logic [DIST_W-1:0]   dist_r;
  logic [MINW_W-1:0]   minw_r;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic                armed_r, armed_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]    centre_r, centre_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    begin_r, begin_nxt;
  logic                phase_end_r, phase_end_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    lim_r, lim_nxt;
  logic [MEAN_W-1:0]   mean_r, mean_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_r, out_nxt;

  logic                in_acc;
  logic                room;
  logic [CNT_W-1:0]    fill_after;
  logic [SUM_W-1:0]    sum_after;
  logic [PIX_W-1:0]    pix_in;
  logic                ram_we;
  logic [IDX_W-1:0]    raddr_a, raddr_b;
  logic [PIX_W-1:0]    rdata_a, rdata_b;
  logic [MEAN_W-1:0]   val_a, val_b;
  logic                above, below;
  logic [CNT_W-1:0]    dist_ext;
  logic [CNT_W-1:0]    pos_inc;
  logic [IDX_W-1:0]    width;
  logic [IDX_W:0]      mid_sum;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // fill bookkeeping: pixels past the row length are dropped
  assign pix_in     = in_data.pixel_byte[BYTE_W-1:PIX_SHIFT];
  assign room       = (fill_r < CNT_W'(ROW_LENGTH));
  assign fill_after = room ? fill_r + CNT_W'(1) : fill_r;
  assign sum_after  = room ? sum_r + SUM_W'({pix_in, {PIX_SHIFT{1'b0}}}) : sum_r;

  // shared compare step against the mean
  assign val_a    = {rdata_a, {PIX_SHIFT{1'b0}}};
  assign val_b    = {rdata_b, {PIX_SHIFT{1'b0}}};
  assign above    = (val_a > mean_r);
  assign below    = (val_b < mean_r);
  assign dist_ext = CNT_W'(dist_r);
  assign pos_inc  = pos_r + CNT_W'(1);
  assign width    = pos_r[IDX_W-1:0] - begin_r;
  assign mid_sum  = {1'b0, begin_r} + {1'b0, pos_r[IDX_W-1:0]};

  rdl_ram #(
    .WIDTH (PIX_W),
    .DEPTH (ROW_LENGTH)
  ) u_row_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (fill_r[IDX_W-1:0]),
    .wdata   (pix_in),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  rdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    armed_nxt     = armed_r;
    total_nxt     = total_r;
    centre_nxt    = centre_r;
    pos_nxt       = pos_r;
    begin_nxt     = begin_r;
    phase_end_nxt = phase_end_r;
    found_nxt     = found_r;
    n_nxt         = n_r;
    lim_nxt       = lim_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    raddr_a       = '0;
    raddr_b       = '0;
    div_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.command)
            CMD_ARM:    armed_nxt = 1'b1;
            CMD_DISARM: armed_nxt = 1'b0;
            CMD_CLEAR:  total_nxt = '0;
            default: begin
              ram_we = room;
              if (in_data.last_pixel) begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_after;
                div_req.divisor  = fill_after;
                n_nxt            = fill_after;
                fill_nxt         = '0;
                sum_nxt          = '0;
                found_nxt        = 1'b0;
                state_nxt        = S_DIV;
              end else begin
                fill_nxt = fill_after;
                sum_nxt  = sum_after;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mean_nxt      = div_rsp.quotient;
          lim_nxt       = (n_r > dist_ext) ? n_r - dist_ext : '0;
          pos_nxt       = '0;
          phase_end_nxt = 1'b0;
          state_nxt     = armed_r ? S_RD : S_DONE;
        end
      end
      S_RD: begin
        // issue both reads of one edge test
        if (!phase_end_r) begin
          if (pos_r >= lim_r) begin
            state_nxt = S_DONE;
          end else begin
            raddr_a   = pos_r[IDX_W-1:0];
            raddr_b   = IDX_W'(pos_r + dist_ext);
            state_nxt = S_EV;
          end
        end else begin
          if (pos_r >= n_r) begin
            state_nxt = S_DONE;
          end else begin
            raddr_a   = pos_r[IDX_W-1:0];
            raddr_b   = IDX_W'(pos_r - dist_ext);
            state_nxt = S_EV;
          end
        end
      end
      S_EV: begin
        state_nxt = S_RD;
        if (!phase_end_r) begin
          // start edge: bright here, dark ahead
          pos_nxt = pos_inc;
          if (above && below) begin
            begin_nxt = pos_r[IDX_W-1:0];
            if (pos_inc >= lim_r) begin
              state_nxt = S_DONE;
            end else begin
              phase_end_nxt = 1'b1;
            end
          end
        end else if ((pos_r >= dist_ext) && above && below) begin
          // end edge: next start search resumes at the end pixel
          phase_end_nxt = 1'b0;
          if (DIFF_W'(width) >= DIFF_W'(minw_r)) begin
            centre_nxt = mid_sum[IDX_W:1];
            total_nxt  = (total_r == TOTAL_MAX) ? total_r : total_r + TOTAL_W'(1);
            found_nxt  = 1'b1;
            if (first_r) begin
              state_nxt = S_DONE;
            end
          end
        end else begin
          pos_nxt = pos_inc;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          armed_nxt            = (total_r != '0) ? 1'b0 : armed_r;
          out_valid_nxt        = 1'b1;
          out_nxt.row_has_line = found_r;
          out_nxt.line_centre  = CENTRE_W'(centre_r);
          out_nxt.line_total   = total_r;
          out_nxt.search_on    = (total_r != '0) ? 1'b0 : armed_r;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      armed_r     <= 1'b0;
      total_r     <= '0;
      centre_r    <= IDX_W'(ROW_LENGTH / 2);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      armed_r     <= armed_nxt;
      total_r     <= total_nxt;
      centre_r    <= centre_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan datapath and output beat
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    begin_r     <= begin_nxt;
    phase_end_r <= phase_end_nxt;
    found_r     <= found_nxt;
    n_r         <= n_nxt;
    lim_r       <= lim_nxt;
    mean_r      <= mean_nxt;
    out_r       <= out_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
      dist_r  <= DIST_RST;
      minw_r  <= MINW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIRST_ONLY: first_r <= cfg_data[0];
        CFG_EDGE_DIST:  dist_r  <= cfg_data[DIST_W-1:0];
        CFG_MIN_WIDTH:  minw_r  <= cfg_data[MINW_W-1:0];
        default: ;
      endcase
    end
  end

  // a new result beat only ever comes out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the done state");

  // every compare step sits at a position inside the current row
  a_scan_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV) |-> (pos_r < n_r))
    else $error("scan index beyond the received row");

  // the line count only steps up by one unless cleared
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (total_r != $past(total_r)) &&
     !$past(in_acc && (in_data.command == CMD_CLEAR)))
    |-> (total_r == $past(total_r) + TOTAL_W'(1)))
    else $error("line count changed without a line or a clear");

  // a found line leaves a nonzero count and a disarmed search
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.row_has_line) |-> ((out_r.line_total != '0) && !out_r.search_on))
    else $error("line reported with zero count or armed search");

endmodule

/* hw/rtl/rdl_ram.sv */
// rdl_ram: generic ram, one write port and two registered read ports
// no package dependency
module rdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

/* hw/rtl/rdl_div.sv */
// rdl_div: restoring divider, one quotient bit per cycle, for the row mean
// depends on rdl_pkg
module rdl_div
  import rdl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DSTEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     trial;
  logic               fits;

  // one shift-subtract step
  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_r};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = DSTEP_W'(SUM_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      step_nxt = step_r - DSTEP_W'(1);
      if (step_r == DSTEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  // mean of stored bytes never exceeds one byte
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r[MEAN_W-1:0];

  // done pulses only at the end of a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule
